/* rtl/lsa_pkg.sv */
// Shared types, widths and codes of the light slot allocator.
package lsa_pkg;

    localparam int NUM_LIGHTS_DEF = 32;
    localparam int KEY_W          = 16;
    localparam int TIME_W         = 32;
    localparam int POS_W          = 16;
    localparam int RAD_W          = 24;
    localparam int SLOT_W         = 5;
    localparam int CHOICE_W       = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [CHOICE_W-1:0] {
        CH_KEY      = 2'd0,
        CH_EXPIRED  = 2'd1,
        CH_FARTHEST = 2'd2,
        CH_TICK     = 2'd3
    } choice_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIST,
        ST_WRITE,
        ST_TICK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic        [KEY_W-1:0]  key;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  z;
        logic        [RAD_W-1:0]  radius;
        logic        [TIME_W-1:0] expiry;
        logic        [RAD_W-1:0]  decay;
    } entry_t;

endpackage

/* rtl/lsa_cell.sv */
// One cell of the light entry ring: holds one entry and passes it on when the ring turns.
module lsa_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  lsa_pkg::entry_t d,
    output lsa_pkg::entry_t q
);
    import lsa_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

/* rtl/lsa_ctrl.sv */
// Sequencer at the head of the ring: searches, writes and decays entries as they pass.
module lsa_ctrl #(
    parameter int NUM_LIGHTS = lsa_pkg::NUM_LIGHTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic        [lsa_pkg::KEY_W-1:0]   light_key,
    input  logic        [lsa_pkg::TIME_W-1:0]  now_time,
    input  logic signed [lsa_pkg::POS_W-1:0]   view_x,
    input  logic signed [lsa_pkg::POS_W-1:0]   view_y,
    input  logic signed [lsa_pkg::POS_W-1:0]   view_z,
    input  logic signed [lsa_pkg::POS_W-1:0]   pos_x,
    input  logic signed [lsa_pkg::POS_W-1:0]   pos_y,
    input  logic signed [lsa_pkg::POS_W-1:0]   pos_z,
    input  logic        [lsa_pkg::RAD_W-1:0]   start_radius,
    input  logic        [lsa_pkg::TIME_W-1:0]  expiry_time,
    input  logic        [lsa_pkg::RAD_W-1:0]   decay_rate,
    input  lsa_pkg::entry_t                    head,
    output logic                               shift,
    output lsa_pkg::entry_t                    wrap,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic        [lsa_pkg::SLOT_W-1:0]  slot,
    output logic        [lsa_pkg::CHOICE_W-1:0] choice
);
    import lsa_pkg::*;

    localparam int IDX_W  = $clog2(NUM_LIGHTS);
    localparam int SQ_W   = 2 * POS_W;
    localparam int DIST_W = SQ_W + 2;
    localparam int LOSS_W = TIME_W + RAD_W;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic signed [POS_W-1:0] vx_reg, vx_next, vy_reg, vy_next, vz_reg, vz_next;
    entry_t              new_reg, new_next;
    logic [TIME_W-1:0]   prev_tick_reg, prev_tick_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic                key_hit_reg, key_hit_next;
    logic [IDX_W-1:0]    key_idx_reg, key_idx_next;
    logic                exp_hit_reg, exp_hit_next;
    logic [IDX_W-1:0]    exp_idx_reg, exp_idx_next;
    logic                dv_reg, dv_next;
    logic [IDX_W-1:0]    didx_reg, didx_next;
    logic [SQ_W-1:0]     sqx_reg, sqx_next, sqy_reg, sqy_next, sqz_reg, sqz_next;
    logic [DIST_W-1:0]   best_reg, best_next;
    logic [IDX_W-1:0]    far_idx_reg, far_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CHOICE_W-1:0] choice_reg, choice_next;

    logic                cnt_last;
    logic                head_expired;
    logic signed [POS_W:0] dx, dy, dz;
    logic [POS_W-1:0]    ax, ay, az;
    logic [DIST_W-1:0]   dsum;
    logic [LOSS_W-1:0]   loss;
    logic [RAD_W-1:0]    decayed;
    logic [IDX_W-1:0]    pick;
    choice_t             pick_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            prev_tick_reg <= '0;
            key_hit_reg   <= 1'b0;
            exp_hit_reg   <= 1'b0;
            dv_reg        <= 1'b0;
            best_reg      <= '0;
            far_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prev_tick_reg <= prev_tick_next;
            key_hit_reg   <= key_hit_next;
            exp_hit_reg   <= exp_hit_next;
            dv_reg        <= dv_next;
            best_reg      <= best_next;
            far_idx_reg   <= far_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        now_reg     <= now_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        vz_reg      <= vz_next;
        new_reg     <= new_next;
        elapsed_reg <= elapsed_next;
        key_idx_reg <= key_idx_next;
        exp_idx_reg <= exp_idx_next;
        didx_reg    <= didx_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        sqz_reg     <= sqz_next;
        slot_reg    <= slot_next;
        choice_reg  <= choice_next;
    end

    assign cnt_last     = (cnt_reg == IDX_W'(NUM_LIGHTS - 1));
    assign head_expired = (head.expiry < now_reg);

    assign dx = {head.x[POS_W-1], head.x} - {vx_reg[POS_W-1], vx_reg};
    assign dy = {head.y[POS_W-1], head.y} - {vy_reg[POS_W-1], vy_reg};
    assign dz = {head.z[POS_W-1], head.z} - {vz_reg[POS_W-1], vz_reg};
    assign ax = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
    assign ay = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
    assign az = dz[POS_W] ? POS_W'(-dz) : dz[POS_W-1:0];
    assign dsum = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);

    assign loss    = LOSS_W'(elapsed_reg) * LOSS_W'(head.decay);
    assign decayed = (loss >= LOSS_W'(head.radius)) ? '0 : head.radius - loss[RAD_W-1:0];

    always_comb
    begin
        if (key_hit_reg)
        begin
            pick      = key_idx_reg;
            pick_kind = CH_KEY;
        end
        else if (exp_hit_reg)
        begin
            pick      = exp_idx_reg;
            pick_kind = CH_EXPIRED;
        end
        else
        begin
            pick      = far_idx_reg;
            pick_kind = CH_FARTHEST;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        now_next       = now_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        vz_next        = vz_reg;
        new_next       = new_reg;
        prev_tick_next = prev_tick_reg;
        elapsed_next   = elapsed_reg;
        key_hit_next   = key_hit_reg;
        key_idx_next   = key_idx_reg;
        exp_hit_next   = exp_hit_reg;
        exp_idx_next   = exp_idx_reg;
        dv_next        = 1'b0;
        didx_next      = didx_reg;
        sqx_next       = sqx_reg;
        sqy_next       = sqy_reg;
        sqz_next       = sqz_reg;
        best_next      = best_reg;
        far_idx_next   = far_idx_reg;
        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        choice_next    = choice_reg;
        shift          = 1'b0;
        wrap           = head;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (dv_reg && (dsum > best_reg))
        begin
            best_next    = dsum;
            far_idx_next = didx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    key_next        = light_key;
                    now_next        = now_time;
                    vx_next         = view_x;
                    vy_next         = view_y;
                    vz_next         = view_z;
                    new_next.key    = light_key;
                    new_next.x      = pos_x;
                    new_next.y      = pos_y;
                    new_next.z      = pos_z;
                    new_next.radius = start_radius;
                    new_next.expiry = expiry_time;
                    new_next.decay  = decay_rate;
                    key_hit_next    = 1'b0;
                    exp_hit_next    = 1'b0;
                    best_next       = '0;
                    far_idx_next    = '0;
                    if (opcode == OP_TICK)
                    begin
                        elapsed_next   = now_time - prev_tick_reg;
                        prev_tick_next = now_time;
                        state_next     = ST_TICK;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                shift = 1'b1;
                if ((key_reg != '0) && !key_hit_reg && (head.key == key_reg))
                begin
                    key_hit_next = 1'b1;
                    key_idx_next = cnt_reg;
                end
                if (!exp_hit_reg && head_expired)
                begin
                    exp_hit_next = 1'b1;
                    exp_idx_next = cnt_reg;
                end
                sqx_next  = ax * ax;
                sqy_next  = ay * ay;
                sqz_next  = az * az;
                didx_next = cnt_reg;
                dv_next   = 1'b1;
                cnt_next  = cnt_last ? '0 : cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = ST_DIST;
                end
            end
            ST_DIST:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                shift = 1'b1;
                if (cnt_reg == pick)
                begin
                    wrap = new_reg;
                end
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_TICK:
            begin
                shift = 1'b1;
                if (!head_expired && (head.radius != '0))
                begin
                    wrap.radius = decayed;
                end
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_TICK)
                    begin
                        slot_next   = '0;
                        choice_next = CH_TICK;
                    end
                    else
                    begin
                        slot_next   = SLOT_W'(pick);
                        choice_next = pick_kind;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign choice    = choice_reg;

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("Result beat raised outside the finish step.");

    a_ring_aligned_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("Ring is not aligned while idle.");

    a_scan_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cnt_last) |=> (state_reg == ST_DIST))
        else $error("Scan pass did not end in the distance drain step.");

    a_expired_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && exp_hit_reg) |=> (exp_hit_reg && $stable(exp_idx_reg)))
        else $error("First expired entry was overwritten during the scan.");

endmodule

/* rtl/light_slot_allocator_top.sv */
// Top level of the light slot allocator: the ring of entry cells and its head sequencer.
// The light table sits in a ring of NUM_LIGHTS cells that, while an operation is under way,
// turns by one entry per clock past a single head sequencer, so every operation costs whole
// turns of the ring. An allocate beat takes one turn to find the key match, the first expired
// entry and the farthest entry, a drain step for the distance pipeline and a second turn to
// write the new light into the chosen slot. A tick beat takes one turn in which each live
// entry is decayed as it passes the head. One beat is worked on at a time; the next is taken
// the cycle after the result is registered, even while that result still waits on the output.
// All entries and the previous tick time clear at reset.
module light_slot_allocator_top #(
    parameter int NUM_LIGHTS = lsa_pkg::NUM_LIGHTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               opcode,
    input  logic        [lsa_pkg::KEY_W-1:0]   light_key,
    input  logic        [lsa_pkg::TIME_W-1:0]  now_time,
    input  logic signed [lsa_pkg::POS_W-1:0]   view_x,
    input  logic signed [lsa_pkg::POS_W-1:0]   view_y,
    input  logic signed [lsa_pkg::POS_W-1:0]   view_z,
    input  logic signed [lsa_pkg::POS_W-1:0]   pos_x,
    input  logic signed [lsa_pkg::POS_W-1:0]   pos_y,
    input  logic signed [lsa_pkg::POS_W-1:0]   pos_z,
    input  logic        [lsa_pkg::RAD_W-1:0]   start_radius,
    input  logic        [lsa_pkg::TIME_W-1:0]  expiry_time,
    input  logic        [lsa_pkg::RAD_W-1:0]   decay_rate,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic        [lsa_pkg::SLOT_W-1:0]  slot,
    output logic        [lsa_pkg::CHOICE_W-1:0] choice
);
    import lsa_pkg::*;

    entry_t cell_q [NUM_LIGHTS];
    entry_t wrap;
    logic   shift;

    genvar i;
    generate
        for (i = 0; i < NUM_LIGHTS; i++)
        begin : g_cell
            entry_t cell_d;
            if (i == NUM_LIGHTS - 1)
            begin : g_tail
                assign cell_d = wrap;
            end
            else
            begin : g_link
                assign cell_d = cell_q[i+1];
            end
            lsa_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_d),
                .q     (cell_q[i])
            );
        end
    endgenerate

    lsa_ctrl #(
        .NUM_LIGHTS (NUM_LIGHTS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .light_key    (light_key),
        .now_time     (now_time),
        .view_x       (view_x),
        .view_y       (view_y),
        .view_z       (view_z),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .start_radius (start_radius),
        .expiry_time  (expiry_time),
        .decay_rate   (decay_rate),
        .head         (cell_q[0]),
        .shift        (shift),
        .wrap         (wrap),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot         (slot),
        .choice       (choice)
    );

endmodule

/* bench/light_slot_allocator_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the light slot allocator: directed and random allocate and tick beats.
module light_slot_allocator_top_tb;
    import lsa_pkg::*;

    localparam int LIGHTS = NUM_LIGHTS_DEF;

    typedef struct {
        logic                     opcode;
        logic        [KEY_W-1:0]  light_key;
        logic        [TIME_W-1:0] now_time;
        logic signed [POS_W-1:0]  view_x;
        logic signed [POS_W-1:0]  view_y;
        logic signed [POS_W-1:0]  view_z;
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [POS_W-1:0]  pos_z;
        logic        [RAD_W-1:0]  start_radius;
        logic        [TIME_W-1:0] expiry_time;
        logic        [RAD_W-1:0]  decay_rate;
    } light_beat_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        choice_t           choice;
    } slot_grant_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       opcode = OP_ALLOC;
    logic        [KEY_W-1:0]    light_key = '0;
    logic        [TIME_W-1:0]   now_time = '0;
    logic signed [POS_W-1:0]    view_x = '0;
    logic signed [POS_W-1:0]    view_y = '0;
    logic signed [POS_W-1:0]    view_z = '0;
    logic signed [POS_W-1:0]    pos_x = '0;
    logic signed [POS_W-1:0]    pos_y = '0;
    logic signed [POS_W-1:0]    pos_z = '0;
    logic        [RAD_W-1:0]    start_radius = '0;
    logic        [TIME_W-1:0]   expiry_time = '0;
    logic        [RAD_W-1:0]    decay_rate = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic        [SLOT_W-1:0]   slot;
    logic        [CHOICE_W-1:0] choice;

    logic        [KEY_W-1:0]  lt_key    [LIGHTS];
    logic signed [POS_W-1:0]  lt_x      [LIGHTS];
    logic signed [POS_W-1:0]  lt_y      [LIGHTS];
    logic signed [POS_W-1:0]  lt_z      [LIGHTS];
    logic        [RAD_W-1:0]  lt_radius [LIGHTS];
    logic        [TIME_W-1:0] lt_expiry [LIGHTS];
    logic        [RAD_W-1:0]  lt_decay  [LIGHTS];
    logic        [TIME_W-1:0] last_tick_time;

    slot_grant_t       grant_due_q[$];
    slot_grant_t       grant_head;
    int                mismatches = 0;
    int                results_seen = 0;
    int                alloc_beats = 0;
    int                tick_beats = 0;
    int                grants_by_kind[4];
    int                rx_hold = 0;
    bit                idling_on = 1'b1;
    logic [TIME_W-1:0] scene_now;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    light_slot_allocator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .light_key    (light_key),
        .now_time     (now_time),
        .view_x       (view_x),
        .view_y       (view_y),
        .view_z       (view_z),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .start_radius (start_radius),
        .expiry_time  (expiry_time),
        .decay_rate   (decay_rate),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .slot         (slot),
        .choice       (choice)
    );

    function automatic void clear_light_table();
        int i;
        for (i = 0; i < LIGHTS; i++)
        begin
            lt_key[i]    = '0;
            lt_x[i]      = '0;
            lt_y[i]      = '0;
            lt_z[i]      = '0;
            lt_radius[i] = '0;
            lt_expiry[i] = '0;
            lt_decay[i]  = '0;
        end
        last_tick_time = '0;
        for (i = 0; i < 4; i++)
            grants_by_kind[i] = 0;
    endfunction

    function automatic void choose_light_slot(input light_beat_t b);
        int                i;
        int                pick;
        choice_t           kind;
        int                dx;
        int                dy;
        int                dz;
        longint unsigned   sq_dist;
        longint unsigned   best;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       loss;
        slot_grant_t       g;
        if (b.opcode == OP_TICK)
        begin
            elapsed = b.now_time - last_tick_time;
            for (i = 0; i < LIGHTS; i++)
            begin
                if (lt_expiry[i] >= b.now_time && lt_radius[i] != '0)
                begin
                    loss = 64'(elapsed) * 64'(lt_decay[i]);
                    if (loss >= 64'(lt_radius[i]))
                        lt_radius[i] = '0;
                    else
                        lt_radius[i] = lt_radius[i] - loss[RAD_W-1:0];
                end
            end
            last_tick_time = b.now_time;
            g.slot = '0;
            g.choice = CH_TICK;
        end
        else
        begin
            pick = -1;
            kind = CH_KEY;
            if (b.light_key != '0)
            begin
                for (i = 0; i < LIGHTS; i++)
                    if (pick < 0 && lt_key[i] == b.light_key)
                        pick = i;
            end
            if (pick < 0)
            begin
                for (i = 0; i < LIGHTS; i++)
                begin
                    if (pick < 0 && lt_expiry[i] < b.now_time)
                    begin
                        pick = i;
                        kind = CH_EXPIRED;
                    end
                end
            end
            if (pick < 0)
            begin
                kind = CH_FARTHEST;
                pick = 0;
                best = 0;
                for (i = 0; i < LIGHTS; i++)
                begin
                    dx = int'(lt_x[i]) - int'(b.view_x);
                    dy = int'(lt_y[i]) - int'(b.view_y);
                    dz = int'(lt_z[i]) - int'(b.view_z);
                    sq_dist = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy)
                            + longint'(dz) * longint'(dz);
                    if (sq_dist > best)
                    begin
                        best = sq_dist;
                        pick = i;
                    end
                end
            end
            lt_key[pick]    = b.light_key;
            lt_x[pick]      = b.pos_x;
            lt_y[pick]      = b.pos_y;
            lt_z[pick]      = b.pos_z;
            lt_radius[pick] = b.start_radius;
            lt_expiry[pick] = b.expiry_time;
            lt_decay[pick]  = b.decay_rate;
            g.slot = pick[SLOT_W-1:0];
            g.choice = kind;
        end
        grants_by_kind[g.choice]++;
        grant_due_q.push_back(g);
    endfunction

    function automatic light_beat_t make_alloc(input logic [KEY_W-1:0] key,
                                               input logic [TIME_W-1:0] now,
                                               input int vx, input int vy, input int vz,
                                               input int px, input int py, input int pz,
                                               input logic [RAD_W-1:0] radius,
                                               input logic [TIME_W-1:0] expiry,
                                               input logic [RAD_W-1:0] decay);
        light_beat_t b;
        b.opcode       = OP_ALLOC;
        b.light_key    = key;
        b.now_time     = now;
        b.view_x       = POS_W'(vx);
        b.view_y       = POS_W'(vy);
        b.view_z       = POS_W'(vz);
        b.pos_x        = POS_W'(px);
        b.pos_y        = POS_W'(py);
        b.pos_z        = POS_W'(pz);
        b.start_radius = radius;
        b.expiry_time  = expiry;
        b.decay_rate   = decay;
        return b;
    endfunction

    function automatic light_beat_t make_tick(input logic [TIME_W-1:0] now);
        light_beat_t b;
        b = make_alloc('0, now, 0, 0, 0, 0, 0, 0, '0, '0, '0);
        b.opcode = OP_TICK;
        return b;
    endfunction

    function automatic logic [POS_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3, 4: return POS_W'($urandom_range(0, 2000) - 1000);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic light_beat_t random_beat();
        light_beat_t b;
        scene_now = scene_now + $urandom_range(0, 200);
        if ($urandom_range(0, 31) == 0)
            scene_now = $urandom;
        b.opcode = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_ALLOC;
        b.now_time = scene_now;
        if ($urandom_range(0, 9) == 0)
            b.now_time = scene_now - $urandom_range(0, 500);
        case ($urandom_range(0, 9))
            0, 1:    b.light_key = '0;
            9:       b.light_key = KEY_W'($urandom);
            default: b.light_key = KEY_W'($urandom_range(1, 12));
        endcase
        b.view_x = rand_coord();
        b.view_y = rand_coord();
        b.view_z = rand_coord();
        b.pos_x  = rand_coord();
        b.pos_y  = rand_coord();
        b.pos_z  = rand_coord();
        if ($urandom_range(0, 1) == 0)
            b.start_radius = RAD_W'($urandom);
        else
            b.start_radius = RAD_W'($urandom_range(0, 4096));
        case ($urandom_range(0, 9))
            0:       b.expiry_time = '1;
            1:       b.expiry_time = $urandom;
            2:       b.expiry_time = scene_now;
            default: b.expiry_time = scene_now + $urandom_range(0, 8000);
        endcase
        case ($urandom_range(0, 9))
            0, 1:    b.decay_rate = RAD_W'($urandom);
            2, 3, 4: b.decay_rate = RAD_W'($urandom_range(0, 4096));
            default: b.decay_rate = RAD_W'($urandom_range(0, 64));
        endcase
        return b;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on %s at %0t: expected %0d, got %0d", what, $time, want, got);
    endtask

    task automatic send_beat(input light_beat_t b);
        in_valid     <= 1'b1;
        opcode       <= b.opcode;
        light_key    <= b.light_key;
        now_time     <= b.now_time;
        view_x       <= b.view_x;
        view_y       <= b.view_y;
        view_z       <= b.view_z;
        pos_x        <= b.pos_x;
        pos_y        <= b.pos_y;
        pos_z        <= b.pos_z;
        start_radius <= b.start_radius;
        expiry_time  <= b.expiry_time;
        decay_rate   <= b.decay_rate;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        choose_light_slot(b);
        if (b.opcode == OP_TICK)
            tick_beats++;
        else
            alloc_beats++;
    endtask

    task automatic sender_idle();
        int gap;
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (grant_due_q.size() == 0)
                begin
                    flag_mismatch("unexpected result, slot", -1, int'(slot));
                end
                else
                begin
                    grant_head = grant_due_q.pop_front();
                    if (slot !== grant_head.slot)
                        flag_mismatch("slot", int'(grant_head.slot), int'(slot));
                    if (choice !== grant_head.choice)
                        flag_mismatch("choice", int'(grant_head.choice), int'(choice));
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                if (rx_hold == 0)
                    out_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                rx_hold = $urandom_range(1, 16);
                out_stall <= 1'b1;
            end
        end
    end

    task automatic test_empty_table();
        send_beat(make_alloc(16'h1234, 0, 0, 0, 0, 0, 0, 0, 24'h000100, 32'd0, 24'd0));
        sender_idle();
        send_beat(make_alloc(16'hffff, 0, -32768, -32768, -32768, 32767, 32767, 32767,
                             24'hffffff, 32'hffffffff, 24'hffffff));
        send_beat(make_alloc(16'h0000, 0, 32767, 32767, 32767, -32768, -32768, -32768,
                             24'h000001, 32'd0, 24'd0));
    endtask

    task automatic test_key_matching();
        send_beat(make_alloc(16'hffff, 0, 0, 0, 0, -32768, 32767, 0,
                             24'h800000, 32'hffffffff, 24'h000010));
        sender_idle();
        send_beat(make_alloc(16'h0001, 0, -32768, 32767, 0, 1000, -1000, 5,
                             24'h001000, 32'd500, 24'h000003));
        send_beat(make_alloc(16'h0001, 0, 0, 0, 0, 7, 7, 7, 24'h002000, 32'd500, 24'h000004));
        send_beat(make_alloc(16'h0000, 0, 0, 0, 0, 1, 2, 3, 24'h000010, 32'd100, 24'h000001));
    endtask

    task automatic test_expiry_search();
        send_beat(make_alloc(16'h4242, 100, 0, 0, 0, 50, 50, 50, 24'h000400, 32'd100, 24'h000002));
        send_beat(make_alloc(16'h4242, 100, 0, 0, 0, 60, 60, 60, 24'h000400, 32'd100, 24'h000002));
        sender_idle();
        send_beat(make_alloc(16'h7777, 101, 0, 0, 0, -5, -5, -5, 24'h0fffff, 32'hffffffff,
                             24'h000100));
        send_beat(make_alloc(16'h0000, 32'hffffffff, 0, 0, 0, 9, 9, 9, 24'h000fff, 32'hffffffff,
                             24'h000001));
    endtask

    task automatic test_decay_ticks();
        send_beat(make_tick(32'd50));
        send_beat(make_tick(32'd50));
        sender_idle();
        send_beat(make_tick(32'd10));
        send_beat(make_tick(32'hffffffff));
        send_beat(make_tick(32'd0));
        send_beat(make_alloc(16'h0000, 0, 100, -100, 100, 0, 0, 0, 24'h000050, 32'd0, 24'd0));
    endtask

    task automatic test_random_traffic(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 64 == 0)
                idling_on = ($urandom_range(0, 3) != 0);
            sender_idle();
            send_beat(random_beat());
        end
        idling_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        if (grant_due_q.size() != 0)
        begin
            in_valid <= 1'b0;
            while (grant_due_q.size() != 0)
                @(posedge clk);
        end
        send_beat(random_beat());
    endtask

    task automatic test_steady_tail(input int count);
        int n;
        idling_on = 1'b0;
        for (n = 0; n < count; n++)
            send_beat(random_beat());
    endtask

    initial
    begin : stimulus
        int waited;
        int leftovers;
        clear_light_table();
        scene_now = $urandom_range(0, 1000);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_key_matching();
        test_expiry_search();
        test_decay_ticks();
        test_random_traffic(700);
        test_drain_pause();
        test_random_traffic(500);
        test_drain_pause();
        test_steady_tail(330);
        in_valid <= 1'b0;
        waited = 0;
        while (grant_due_q.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4 * LIGHTS) @(posedge clk);
        leftovers = grant_due_q.size();
        if (leftovers != 0)
            $display("%0d expected results never arrived", leftovers);
        $display("Run covered %0d allocate and %0d tick beats, %0d results checked.",
                 alloc_beats, tick_beats, results_seen);
        $display("Allocations went %0d by key, %0d to expired slots, %0d to the farthest slot.",
                 grants_by_kind[CH_KEY], grants_by_kind[CH_EXPIRED], grants_by_kind[CH_FARTHEST]);
        if (mismatches == 0 && leftovers == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
